### hw/rtl/wcas_pkg.sv
// ----------------------------------------------------------------------------
// wcas_pkg
// Shared types and constants of the wall clock alarm scheduler.
// ----------------------------------------------------------------------------
package wcas_pkg;

    // Field widths of the item and result transfers
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int DSEC_W  = 16;
    localparam int MSEC_W  = 10;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 16;
    localparam int RSEC_W  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REG   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNREG = 2'd2;

    // Clock limits
    localparam logic [MSEC_W-1:0] MSEC_MAX = 10'd999;

    // Wall time, packed so that a plain compare is lexicographic
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  min;
        logic [SEC_W-1:0]  sec;
        logic [MSEC_W-1:0] msec;
    } wall_time_t;

    // Content of one list position
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        wall_time_t        due;
        logic [DSEC_W-1:0] dsec;
        logic [MSEC_W-1:0] dmsec;
        logic              rep;
    } cell_data_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] slot;
        cell_data_t        data;
    } cell_ctl_t;

endpackage

### hw/rtl/wcas_in_if.sv
// ----------------------------------------------------------------------------
// wcas_in_if
// Item channel: command and alarm slot set-up, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcas_in_if;
    logic                        valid;
    logic                        ready;
    logic [wcas_pkg::CMD_W-1:0]  command;
    logic [wcas_pkg::SLOT_W-1:0] slot;
    logic [wcas_pkg::DSEC_W-1:0] delay_sec;
    logic [wcas_pkg::MSEC_W-1:0] delay_msec;
    logic                        recurring;

    modport source (output valid, command, slot, delay_sec, delay_msec, recurring,
                    input ready);
    modport sink   (input valid, command, slot, delay_sec, delay_msec, recurring,
                    output ready);
endinterface

### hw/rtl/wcas_out_if.sv
// ----------------------------------------------------------------------------
// wcas_out_if
// Result channel: alarm fire flag and wall clock, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcas_out_if;
    logic                        valid;
    logic                        ready;
    logic                        fired;
    logic [wcas_pkg::SLOT_W-1:0] fired_slot;
    logic [wcas_pkg::MSEC_W-1:0] now_msec;
    logic [wcas_pkg::SEC_W-1:0]  now_sec;
    logic [wcas_pkg::MIN_W-1:0]  now_min;
    logic [wcas_pkg::HOUR_W-1:0] now_hour;
    logic [wcas_pkg::DAY_W-1:0]  now_day;
    logic [wcas_pkg::RSEC_W-1:0] running_seconds;

    modport source (output valid, fired, fired_slot, now_msec, now_sec, now_min,
                    now_hour, now_day, running_seconds, input ready);
    modport sink   (input valid, fired, fired_slot, now_msec, now_sec, now_min,
                    now_hour, now_day, running_seconds, output ready);
endinterface

### hw/rtl/wcas_clock.sv
// ----------------------------------------------------------------------------
// wcas_clock
// Millisecond wall clock with cascaded carries and a free running seconds count.
// ----------------------------------------------------------------------------
module wcas_clock (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    output wcas_pkg::wall_time_t        now,
    output logic [wcas_pkg::RSEC_W-1:0] run_sec
);
    wcas_pkg::wall_time_t        now_reg,  now_next;
    logic [wcas_pkg::RSEC_W-1:0] rsec_reg, rsec_next;

    // one millisecond step, carry rippling up through the fields
    always_comb
    begin
        now_next  = now_reg;
        rsec_next = rsec_reg;
        if (advance)
        begin
            if (now_reg.msec == 10'd999)
            begin
                now_next.msec = '0;
                rsec_next     = rsec_reg + 32'd1;
                if (now_reg.sec == 6'd59)
                begin
                    now_next.sec = '0;
                    if (now_reg.min == 6'd59)
                    begin
                        now_next.min = '0;
                        if (now_reg.hour == 5'd23)
                        begin
                            now_next.hour = '0;
                            now_next.day  = now_reg.day + 16'd1;
                        end
                        else
                        begin
                            now_next.hour = now_reg.hour + 5'd1;
                        end
                    end
                    else
                    begin
                        now_next.min = now_reg.min + 6'd1;
                    end
                end
                else
                begin
                    now_next.sec = now_reg.sec + 6'd1;
                end
            end
            else
            begin
                now_next.msec = now_reg.msec + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg  <= '0;
            rsec_reg <= '0;
        end
        else
        begin
            now_reg  <= now_next;
            rsec_reg <= rsec_next;
        end
    end

    assign now     = now_reg;
    assign run_sec = rsec_reg;
endmodule

### hw/rtl/wcas_sched.sv
// ----------------------------------------------------------------------------
// wcas_sched
// Five-stage due time unit: clock plus a seconds/milliseconds delay.
// ----------------------------------------------------------------------------
module wcas_sched (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  wcas_pkg::wall_time_t        now,
    input  logic [wcas_pkg::DSEC_W-1:0] dsec,
    input  logic [wcas_pkg::MSEC_W-1:0] dmsec,
    output logic                        done,
    output wcas_pkg::wall_time_t        due
);
    // reciprocals of 60, each low by less than one unit over its range
    localparam logic [17:0] RECIP_A = 18'd139810;   // 2^23 / 60
    localparam logic [11:0] RECIP_B = 12'd2184;     // 2^17 / 60

    logic [4:0] vld_reg;

    // stage 0: millisecond add, carry into the 17-bit seconds total
    logic [10:0] ms_sum;
    logic        ms_c;
    logic [16:0] tot0_reg;
    logic [9:0]  ms0_reg;

    assign ms_sum = 11'(now.msec) + 11'(dmsec);
    assign ms_c   = (ms_sum >= 11'd1000);

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            tot0_reg <= 17'(dsec) + 17'(ms_c);
            ms0_reg  <= ms_c ? 10'(ms_sum - 11'd1000) : ms_sum[9:0];
        end
    end

    // stage 1: estimate of total / 60
    logic [34:0] prod_a;
    logic [10:0] qa1_reg;
    logic [16:0] tot1_reg;
    logic [9:0]  ms1_reg;

    assign prod_a = 35'(tot0_reg) * 35'(RECIP_A);

    always_ff @(posedge clk)
    begin
        qa1_reg  <= prod_a[33:23];
        tot1_reg <= tot0_reg;
        ms1_reg  <= ms0_reg;
    end

    // stage 2: remainder and one-step correction
    logic [16:0] ra;
    logic [10:0] q60_reg;
    logic [5:0]  r60_reg;
    logic [9:0]  ms2_reg;

    assign ra = tot1_reg - 17'(qa1_reg) * 17'd60;

    always_ff @(posedge clk)
    begin
        if (ra >= 17'd60)
        begin
            q60_reg <= qa1_reg + 11'd1;
            r60_reg <= 6'(ra - 17'd60);
        end
        else
        begin
            q60_reg <= qa1_reg;
            r60_reg <= ra[5:0];
        end
        ms2_reg <= ms1_reg;
    end

    // stage 3: seconds field, estimate of minutes / 60
    logic [6:0]  s_sum;
    logic [22:0] prod_b;
    logic [5:0]  sec3_reg;
    logic        c3_reg;
    logic [4:0]  qb3_reg;
    logic [10:0] q3_reg;
    logic [9:0]  ms3_reg;

    assign s_sum  = 7'(now.sec) + 7'(r60_reg);
    assign prod_b = 23'(q60_reg) * 23'(RECIP_B);

    always_ff @(posedge clk)
    begin
        sec3_reg <= (s_sum >= 7'd60) ? 6'(s_sum - 7'd60) : s_sum[5:0];
        c3_reg   <= (s_sum >= 7'd60);
        qb3_reg  <= prod_b[21:17];
        q3_reg   <= q60_reg;
        ms3_reg  <= ms2_reg;
    end

    // stage 4: minute, hour and day fields
    logic [10:0] rb;
    logic [4:0]  qh;
    logic [5:0]  rm;
    logic [6:0]  m_sum;
    logic [5:0]  h_sum;
    logic        mc;
    wcas_pkg::wall_time_t due_reg;

    always_comb
    begin
        rb = q3_reg - 11'(qb3_reg) * 11'd60;
        if (rb >= 11'd60)
        begin
            qh = qb3_reg + 5'd1;
            rm = 6'(rb - 11'd60);
        end
        else
        begin
            qh = qb3_reg;
            rm = rb[5:0];
        end
        m_sum = 7'(now.min) + 7'(rm) + 7'(c3_reg);
        mc    = (m_sum >= 7'd60);
        h_sum = 6'(now.hour) + 6'(qh) + 6'(mc);
    end

    always_ff @(posedge clk)
    begin
        due_reg.msec <= ms3_reg;
        due_reg.sec  <= sec3_reg;
        due_reg.min  <= mc ? 6'(m_sum - 7'd60) : m_sum[5:0];
        due_reg.hour <= (h_sum >= 6'd24) ? 5'(h_sum - 6'd24) : h_sum[4:0];
        due_reg.day  <= now.day + 16'(h_sum >= 6'd24);
    end

    // stage valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], go};
    end

    assign done = vld_reg[4];
    assign due  = due_reg;
endmodule

### hw/rtl/wcas_cell.sv
// ----------------------------------------------------------------------------
// wcas_cell
// One position of the alarm list: holds a slot, its due time and delays.
// ----------------------------------------------------------------------------
module wcas_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wcas_pkg::cell_ctl_t   ctl,
    input  wcas_pkg::wall_time_t  now,
    input  logic                  prev_valid,
    input  logic                  hit_before_in,
    input  logic                  match_before_in,
    input  logic                  next_valid,
    input  wcas_pkg::cell_data_t  next_data,
    output logic                  valid,
    output wcas_pkg::cell_data_t  data,
    output logic                  hit,
    output logic                  hit_before_out,
    output logic                  match_before_out
);
    logic                 valid_reg, valid_next;
    wcas_pkg::cell_data_t data_reg,  data_next;
    logic                 match, due_now;

    // local compares, ranked along the chain
    assign match            = valid_reg && (data_reg.slot == ctl.slot);
    assign due_now          = valid_reg && (now >= data_reg.due);
    assign hit              = due_now && !hit_before_in;
    assign hit_before_out   = hit_before_in || due_now;
    assign match_before_out = match_before_in || match;

    // update in place, append at the first free place, or close a gap
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctl.op)
            wcas_pkg::OP_WRITE:
            begin
                if (match)
                begin
                    data_next = ctl.data;
                end
                else if (!valid_reg && prev_valid && !match_before_in)
                begin
                    valid_next = 1'b1;
                    data_next  = ctl.data;
                end
            end
            wcas_pkg::OP_REMOVE:
            begin
                if (match_before_out)
                begin
                    valid_next = next_valid;
                    data_next  = next_data;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

    // the list stays packed towards the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !prev_valid |-> !valid_reg)
        else $error("list entry occupied behind an empty one");

    // an entry only becomes occupied by a write
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(ctl.op == wcas_pkg::OP_WRITE))
        else $error("list entry filled without a write");
endmodule

### hw/rtl/wall_clock_alarm_scheduler_top.sv
// ----------------------------------------------------------------------------
// wall_clock_alarm_scheduler_top
// Millisecond wall clock with an insertion-ordered list of alarm slots.
// ----------------------------------------------------------------------------
// One item is handled at a time. After the transfer, an unknown command goes
// straight to the result, an unregister passes through the remove state, a
// tick scans the list and, if a one-shot alarm is due, removes it, and a
// register item (after a wait state) or a tick that fires a recurring alarm
// waits on the five-stage due time unit. While the output register still
// holds an untaken result, the next result waits in the sequencer and the
// input stalls. The list is a row of SLOTS cells, one per list position, that
// close up towards the head on removal. A new item is taken while the
// previous result still waits in the output register.
module wall_clock_alarm_scheduler_top #(
    parameter int SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    wcas_in_if.sink     item,
    wcas_out_if.source  result
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_SCHED  = 6'b000100,
        ST_REMOVE = 6'b001000,
        ST_DONE   = 6'b010000,
        ST_WAIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [wcas_pkg::CMD_W-1:0]  cmd_reg;
    logic [wcas_pkg::SLOT_W-1:0] slot_reg;
    logic [wcas_pkg::DSEC_W-1:0] dsec_reg;
    logic [wcas_pkg::MSEC_W-1:0] dms_reg;
    logic                        rep_reg;
    logic                        fired_reg;
    logic [wcas_pkg::SLOT_W-1:0] fired_slot_reg;
    logic                        go_reg;
    logic                        out_valid_reg;

    logic                        accept, slot_ok, out_load;
    wcas_pkg::wall_time_t        now, due;
    logic [wcas_pkg::RSEC_W-1:0] run_sec;
    logic                        sched_done;
    wcas_pkg::cell_ctl_t         ctl;

    logic [SLOTS-1:0]            cell_valid, cell_hit;
    logic [SLOTS:0]              hit_chain, match_chain;
    wcas_pkg::cell_data_t        cell_data [SLOTS];
    wcas_pkg::cell_data_t        hit_data;

    assign accept  = item.valid && item.ready;
    assign slot_ok = (32'(item.slot) < SLOTS);

    // wall clock
    wcas_clock u_clock (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept && (item.command == wcas_pkg::CMD_TICK)),
        .now     (now),
        .run_sec (run_sec)
    );

    // due time unit, shared by register and recurring fire
    wcas_sched u_sched (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .now   (now),
        .dsec  (dsec_reg),
        .dmsec (dms_reg),
        .done  (sched_done),
        .due   (due)
    );

    // list cells
    assign hit_chain[0]   = 1'b0;
    assign match_chain[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic                 pv, nv;
        wcas_pkg::cell_data_t nd;
        if (i == 0)
        begin : g_head
            assign pv = 1'b1;
        end
        else
        begin : g_body
            assign pv = cell_valid[i-1];
        end
        if (i == SLOTS - 1)
        begin : g_tail
            assign nv = 1'b0;
            assign nd = '0;
        end
        else
        begin : g_inner
            assign nv = cell_valid[i+1];
            assign nd = cell_data[i+1];
        end
        wcas_cell u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctl              (ctl),
            .now              (now),
            .prev_valid       (pv),
            .hit_before_in    (hit_chain[i]),
            .match_before_in  (match_chain[i]),
            .next_valid       (nv),
            .next_data        (nd),
            .valid            (cell_valid[i]),
            .data             (cell_data[i]),
            .hit              (cell_hit[i]),
            .hit_before_out   (hit_chain[i+1]),
            .match_before_out (match_chain[i+1])
        );
    end

    // contents of the first due entry (hits are one-hot)
    always_comb
    begin
        hit_data = '0;
        for (int i = 0; i < SLOTS; i++)
            hit_data = hit_data | (cell_hit[i] ? cell_data[i] : '0);
    end

    // command to the cells
    always_comb
    begin
        ctl.op         = wcas_pkg::OP_NONE;
        ctl.slot       = slot_reg;
        ctl.data.slot  = slot_reg;
        ctl.data.due   = due;
        ctl.data.dsec  = dsec_reg;
        ctl.data.dmsec = dms_reg;
        ctl.data.rep   = rep_reg;
        if ((state_reg == ST_SCHED) && sched_done)
            ctl.op = wcas_pkg::OP_WRITE;
        else if (state_reg == ST_REMOVE)
            ctl.op = wcas_pkg::OP_REMOVE;
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == wcas_pkg::CMD_TICK)
                        state_next = ST_SCAN;
                    else if ((item.command == wcas_pkg::CMD_REG) && slot_ok)
                        state_next = ST_WAIT;
                    else if ((item.command == wcas_pkg::CMD_UNREG) && slot_ok)
                        state_next = ST_REMOVE;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (!hit_chain[SLOTS])
                    state_next = ST_DONE;
                else if (hit_data.rep)
                    state_next = ST_SCHED;
                else
                    state_next = ST_REMOVE;
            end
            ST_WAIT:   state_next = ST_SCHED;
            ST_SCHED:  state_next = sched_done ? ST_DONE : ST_SCHED;
            ST_REMOVE: state_next = ST_DONE;
            ST_DONE:   state_next = out_load ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next == ST_SCHED) && (state_reg != ST_SCHED);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item and fire registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.command;
            slot_reg  <= item.slot;
            dsec_reg  <= item.delay_sec;
            dms_reg   <= (item.delay_msec > wcas_pkg::MSEC_MAX) ?
                         wcas_pkg::MSEC_MAX : item.delay_msec;
            rep_reg   <= item.recurring;
            fired_reg <= 1'b0;
            fired_slot_reg <= '0;
        end
        else if ((state_reg == ST_SCAN) && hit_chain[SLOTS])
        begin
            slot_reg       <= hit_data.slot;
            dsec_reg       <= hit_data.dsec;
            dms_reg        <= hit_data.dmsec;
            rep_reg        <= hit_data.rep;
            fired_reg      <= 1'b1;
            fired_slot_reg <= hit_data.slot;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result.fired           <= fired_reg;
            result.fired_slot      <= fired_slot_reg;
            result.now_msec        <= now.msec;
            result.now_sec         <= now.sec;
            result.now_min         <= now.min;
            result.now_hour        <= now.hour;
            result.now_day         <= now.day;
            result.running_seconds <= run_sec;
        end
    end

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;

    // the due time unit only finishes while the sequencer waits for it
    a_sched: assert property (@(posedge clk) disable iff (!rst_n)
        sched_done |-> (state_reg == ST_SCHED))
        else $error("due time unit finished outside scheduling");

    // only a tick can fire an alarm
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && fired_reg |-> (cmd_reg == wcas_pkg::CMD_TICK))
        else $error("alarm fired on an item that is not a tick");
endmodule
